// ===== rtl/ste_pkg.sv =====
// Package for the sorted table engine.
// Holds the transaction structs, operation and status codes, and cell control types.
// No dependencies; every other file refers to it by scoped names.
package ste_pkg;

	// Default table geometry.
	localparam int DEPTH       = 64;
	localparam int VALUE_WIDTH = 32;

	// Fixed field widths of the transaction ports.
	localparam int KIND_W  = 2;
	localparam int VALUE_W = 32;
	localparam int FIELD_W = 7;
	localparam int STAT_W  = 2;

	// Operation codes carried in the kind field.
	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_SEARCH = 2'd2
	} kind_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		STAT_DONE = 2'd0,
		STAT_FULL = 2'd1,
		STAT_MISS = 2'd2
	} status_t;

	// Input transaction.
	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [VALUE_W-1:0] value;
	} op_t;

	// Result transaction.
	typedef struct packed {
		logic               found;
		logic [FIELD_W-1:0] position;
		logic [FIELD_W-1:0] count;
		logic [STAT_W-1:0]  status;
	} result_t;

	// Command broadcast to every cell of the row.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CMP,
		CELL_INS,
		CELL_DEL
	} cell_cmd_t;

	// Flags that a cell shows to its neighbors and to the control logic.
	typedef struct packed {
		logic valid;
		logic lt;
		logic le;
		logic lt_head;
		logic le_head;
		logic hit;
	} cell_flags_t;

	// Engine sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_EXEC,
		ST_DEL,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/ste_cell.sv =====
// One cell of the sorted row: holds one entry, its valid bit and its compare flags.
// Shifts toward either neighbor on command. Depends on ste_pkg.
module ste_cell #(
	parameter int VALUE_WIDTH = ste_pkg::VALUE_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ste_pkg::cell_cmd_t      cmd,
	input  logic [VALUE_WIDTH-1:0]  key,
	input  logic [VALUE_WIDTH-1:0]  prev_entry,
	input  ste_pkg::cell_flags_t    prev_flags,
	input  logic [VALUE_WIDTH-1:0]  next_entry,
	input  ste_pkg::cell_flags_t    next_flags,
	output logic [VALUE_WIDTH-1:0]  entry,
	output ste_pkg::cell_flags_t    flags
);

	logic [VALUE_WIDTH-1:0] entry_q;
	logic                   valid_q;
	logic                   lt_q;
	logic                   le_q;
	logic                   lt_cmp;
	logic                   le_cmp;

	// Signed compare of the held entry against the broadcast key.
	assign lt_cmp = $signed(entry_q) <  $signed(key);
	assign le_cmp = $signed(entry_q) <= $signed(key);

	// Entry data: the insertion point takes the key, cells above it take the
	// left neighbor; on delete every cell at or above the head takes the right one.
	always_ff @(posedge clk) begin
		case (cmd)
			ste_pkg::CELL_INS: begin
				if (!le_q) begin
					entry_q <= prev_flags.le ? key : prev_entry;
				end
			end
			ste_pkg::CELL_DEL: begin
				if (!lt_q) begin
					entry_q <= next_entry;
				end
			end
			default: begin
			end
		endcase
	end

	// Valid bit and registered compare flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			le_q    <= 1'b0;
		end else begin
			case (cmd)
				ste_pkg::CELL_CMP: begin
					lt_q <= valid_q & lt_cmp;
					le_q <= valid_q & le_cmp;
				end
				ste_pkg::CELL_INS: begin
					valid_q <= prev_flags.valid;
				end
				ste_pkg::CELL_DEL: begin
					if (!lt_q) begin
						valid_q <= next_flags.valid;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// The head cells mark where the thermometer codes of lt and le end.
	assign entry         = entry_q;
	assign flags.valid   = valid_q;
	assign flags.lt      = lt_q;
	assign flags.le      = le_q;
	assign flags.lt_head = ~lt_q & prev_flags.lt;
	assign flags.le_head = ~le_q & prev_flags.le;
	assign flags.hit     = valid_q & flags.lt_head & (entry_q == key);

endmodule

// ===== rtl/sorted_table_engine.sv =====
// Sorted table engine: a row of cells that keeps signed values in ascending order.
// Depends on ste_pkg and ste_cell.
//
//   Channel  | Handshake                 | Payload            | Direction
//   ---------+---------------------------+--------------------+----------
//   command  | start, busy (start&!busy) | op (ste_pkg::op_t) | in
//   result   | done, one-cycle strobe    | result (result_t)  | out
//
// Insert and search run from one accepted transaction to the next as follows:
// compare in every cell, encode and shift, then the result strobe.
// A delete that removes n equal entries runs a delete loop that closes
// the gap by one entry a cycle and stops once it sees that none is left.
// A delete that finds nothing goes straight to the result strobe, like a search.
// A new transaction is accepted in the cycle that shows the result.
// Reset clears the valid bits and the count; the table is empty after reset.
// The receiver cannot stall: done lasts exactly one cycle.
module sorted_table_engine #(
	parameter int DEPTH       = ste_pkg::DEPTH,
	parameter int VALUE_WIDTH = ste_pkg::VALUE_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ste_pkg::op_t      op,
	output logic              done,
	output ste_pkg::result_t  result
);

	localparam int IW = $clog2(DEPTH + 1);
	localparam int PW = $clog2(DEPTH + 2);

	ste_pkg::state_t      state_q;
	ste_pkg::state_t      state_d;
	logic [ste_pkg::KIND_W-1:0] kind_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [IW-1:0]        count_q;
	logic [PW-1:0]        pos_q;
	logic                 found_q;
	ste_pkg::status_t     status_q;

	logic                 accept;
	logic                 full;
	logic                 any_hit;
	logic                 found_w;
	logic [IW-1:0]        lo_idx;
	logic [IW-1:0]        hi_idx;
	logic [PW-1:0]        pos_d;
	ste_pkg::status_t     status_d;
	ste_pkg::cell_cmd_t   cell_cmd;
	logic                 cnt_inc;
	logic                 cnt_dec;
	logic [63:0]          value_ext;

	logic [VALUE_WIDTH-1:0] entry_w      [DEPTH];
	ste_pkg::cell_flags_t   flags_w      [DEPTH];
	logic [VALUE_WIDTH-1:0] prev_entry_w [DEPTH];
	ste_pkg::cell_flags_t   prev_flags_w [DEPTH];
	logic [VALUE_WIDTH-1:0] next_entry_w [DEPTH];
	ste_pkg::cell_flags_t   next_flags_w [DEPTH];

	// Operand taken to the table width with sign extension.
	assign value_ext = {{32{op.value[ste_pkg::VALUE_W-1]}}, op.value};
	assign full      = (count_q == IW'(DEPTH));

	// Row of cells; the left end sees an always-less, always-valid neighbor
	// and the right end an empty one.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_entry_w[i] = '0;
			assign prev_flags_w[i] = '{valid: 1'b1, lt: 1'b1, le: 1'b1,
				lt_head: 1'b0, le_head: 1'b0, hit: 1'b0};
		end else begin : g_mid_l
			assign prev_entry_w[i] = entry_w[i-1];
			assign prev_flags_w[i] = flags_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_entry_w[i] = '0;
			assign next_flags_w[i] = '0;
		end else begin : g_mid_r
			assign next_entry_w[i] = entry_w[i+1];
			assign next_flags_w[i] = flags_w[i+1];
		end

		ste_cell #(
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cell_cmd),
			.key        (key_q),
			.prev_entry (prev_entry_w[i]),
			.prev_flags (prev_flags_w[i]),
			.next_entry (next_entry_w[i]),
			.next_flags (next_flags_w[i]),
			.entry      (entry_w[i]),
			.flags      (flags_w[i])
		);
	end

	// Encode the one-hot head markers into indexes and gather the match and hit flags.
	always_comb begin
		lo_idx  = '0;
		hi_idx  = '0;
		found_w = 1'b0;
		any_hit = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (flags_w[i].lt_head) begin
				lo_idx = lo_idx | IW'(i);
			end
			if (flags_w[i].le_head) begin
				hi_idx = hi_idx | IW'(i);
			end
			found_w = found_w | (flags_w[i].le & ~flags_w[i].lt);
			any_hit = any_hit | flags_w[i].hit;
		end
		if (flags_w[DEPTH-1].lt) begin
			lo_idx = lo_idx | IW'(DEPTH);
		end
		if (flags_w[DEPTH-1].le) begin
			hi_idx = hi_idx | IW'(DEPTH);
		end
	end

	// Result position and status, settled in the execute cycle.
	always_comb begin
		if (kind_q == ste_pkg::KIND_INSERT) begin
			pos_d = PW'(hi_idx) + PW'(1);
		end else begin
			pos_d = PW'(lo_idx) + PW'(1);
		end
		status_d = ste_pkg::STAT_DONE;
		if ((kind_q == ste_pkg::KIND_INSERT) && full) begin
			status_d = ste_pkg::STAT_FULL;
		end else if ((kind_q == ste_pkg::KIND_DELETE) && !found_w) begin
			status_d = ste_pkg::STAT_MISS;
		end
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ste_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ste_pkg::ST_CMP;
				end
			end
			ste_pkg::ST_CMP: begin
				state_d = ste_pkg::ST_EXEC;
			end
			ste_pkg::ST_EXEC: begin
				if ((kind_q == ste_pkg::KIND_DELETE) && found_w) begin
					state_d = ste_pkg::ST_DEL;
				end else begin
					state_d = ste_pkg::ST_DONE;
				end
			end
			ste_pkg::ST_DEL: begin
				if (!any_hit) begin
					state_d = ste_pkg::ST_DONE;
				end
			end
			ste_pkg::ST_DONE: begin
				if (start) begin
					state_d = ste_pkg::ST_CMP;
				end else begin
					state_d = ste_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ste_pkg::ST_IDLE;
			end
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		busy     = 1'b0;
		done     = 1'b0;
		cell_cmd = ste_pkg::CELL_HOLD;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		unique case (state_q)
			ste_pkg::ST_IDLE: begin
			end
			ste_pkg::ST_CMP: begin
				busy     = 1'b1;
				cell_cmd = ste_pkg::CELL_CMP;
			end
			ste_pkg::ST_EXEC: begin
				busy = 1'b1;
				if ((kind_q == ste_pkg::KIND_INSERT) && !full) begin
					cell_cmd = ste_pkg::CELL_INS;
					cnt_inc  = 1'b1;
				end
			end
			ste_pkg::ST_DEL: begin
				busy = 1'b1;
				if (any_hit) begin
					cell_cmd = ste_pkg::CELL_DEL;
					cnt_dec  = 1'b1;
				end
			end
			ste_pkg::ST_DONE: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign accept = start & ~busy;

	// Sequencer state and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ste_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				count_q <= count_q + IW'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - IW'(1);
			end
		end
	end

	// Operand capture and result fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= op.kind;
			key_q  <= value_ext[VALUE_WIDTH-1:0];
		end
		if (state_q == ste_pkg::ST_EXEC) begin
			found_q  <= found_w;
			pos_q    <= pos_d;
			status_q <= status_d;
		end
	end

	assign result.found    = found_q;
	assign result.position = ste_pkg::FIELD_W'(pos_q);
	assign result.count    = ste_pkg::FIELD_W'(count_q);
	assign result.status   = status_q;

endmodule

// ===== rtl/ste_checker.sv =====
// Port checker for the sorted table engine, bound to the top level.
// Depends on ste_pkg and sorted_table_engine.
module ste_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input ste_pkg::result_t result
);

	// An accepted transaction occupies the engine in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("engine not busy after accepted transaction");

	// No result can follow an accepted transaction in the very next cycle.
	a_accept_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result strobe one cycle after accept");

	// A result ends a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe without preceding work");

	// A delete that found nothing never reports a match.
	a_miss_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ste_pkg::STAT_MISS)) |-> !result.found)
		else $error("miss status with found set");

endmodule

bind sorted_table_engine ste_checker u_ste_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
